/* hw/rtl/lcc_pkg.sv */
// Shared types, constants and calendar helpers for the lunisolar calendar converter.
package lcc_pkg;

  localparam int FRACTION_BITS = 24;

  localparam int DN_W    = 46;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int KIND_W  = 2;
  localparam int POS_W   = 5;
  localparam int REM_W   = 9;
  localparam int DOY_W   = 10;

  localparam int MONTHS    = 13;
  localparam int MOD_CYCLE = 19;

  localparam logic OP_TO_DAY  = 1'b0;
  localparam logic OP_TO_DATE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_COMMON = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SMALL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BIG    = 2'd2;

  localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;
  localparam logic [DAY_W-1:0]   LAST_DAY   = 5'd30;
  localparam logic [POS_W-1:0]   LAST_POS   = 5'd18;

  // Fixed-point epoch and solar year, rounded half up.
  localparam longint unsigned EPOCH_FX = (64'd1954168 << FRACTION_BITS) +
      (((64'd50623 << FRACTION_BITS) + 64'd500000) / 64'd1000000);
  localparam longint unsigned SOLAR_FX =
      ((64'd1577917828 << FRACTION_BITS) + 64'd2160000) / 64'd4320000;

  // Signed width of day number minus epoch, and of its whole-day part.
  localparam int DIFF_W = (FRACTION_BITS + 23 > 47) ? FRACTION_BITS + 23 : 47;
  localparam int DAYS_W = DIFF_W - FRACTION_BITS;

  // Year estimate: days * RECIP >> RECIP_SHIFT, within one of the true year.
  localparam int RECIP_SHIFT = DAYS_W;
  localparam int RECIP_W     = DAYS_W - 7;
  localparam longint unsigned RECIP = (64'd1 << DIFF_W) / SOLAR_FX;

  localparam int YW      = (DAYS_W - 6 > 15) ? DAYS_W - 6 : 15;
  localparam int SOLAR_W = FRACTION_BITS + 10;
  localparam int PROD_W  = YW + SOLAR_W;
  localparam int NY_W    = ((PROD_W > DIFF_W) ? PROD_W : DIFF_W) + 1;

  // Year mod 19 by reciprocal multiply on an offset, nonnegative year.
  localparam int UW        = YW + 1;
  localparam int MOD_SHIFT = YW + 6;
  localparam int MOD_W     = MOD_SHIFT - 3;
  localparam longint unsigned MOD_MUL =
      ((64'd1 << MOD_SHIFT) + 64'd18) / MOD_CYCLE;
  localparam longint unsigned MOD_OFF =
      MOD_CYCLE * (((64'd1 << (YW - 1)) + 64'd18) / MOD_CYCLE);

  // Days before each month in a common year (month 4 absent).
  localparam logic [8:0] BASE_PREFIX [0:13] = '{
    9'd0, 9'd29, 9'd59, 9'd88, 9'd118, 9'd118, 9'd147,
    9'd177, 9'd206, 9'd236, 9'd265, 9'd295, 9'd324, 9'd354
  };

  typedef struct packed {
    logic               op;
    logic [DN_W-1:0]    day_number_in;
    logic [YEAR_W-1:0]  year_in;
    logic [MONTH_W-1:0] month_in;
    logic [DAY_W-1:0]   day_in;
  } req_t;

  typedef struct packed {
    logic [DN_W-1:0]    day_number_out;
    logic [YEAR_W-1:0]  year_out;
    logic [MONTH_W-1:0] month_out;
    logic [DAY_W-1:0]   day_out;
    logic [KIND_W-1:0]  year_kind;
    logic               clamped;
  } rsp_t;

  function automatic logic [KIND_W-1:0] kind_of(input logic [POS_W-1:0] pos);
    logic [KIND_W-1:0] k;
    case (pos) inside
      5'd7, 5'd18:                      k = KIND_BIG;
      5'd2, 5'd5, 5'd10, 5'd13, 5'd15:  k = KIND_SMALL;
      default:                          k = KIND_COMMON;
    endcase
    return k;
  endfunction

  // Days of the year before month m; months past 12 count the whole year.
  function automatic logic [8:0] month_start(input logic [KIND_W-1:0] kind,
                                             input logic [MONTH_W-1:0] m);
    logic [MONTH_W-1:0] idx;
    logic [8:0]         s;
    idx = (m > 4'd13) ? 4'd13 : m;
    s = BASE_PREFIX[idx];
    if (kind == KIND_BIG && m > 4'd2) s = s + 9'd1;
    if (kind != KIND_COMMON && m > 4'd4) s = s + 9'd30;
    return s;
  endfunction

endpackage

/* hw/rtl/lunisolar_calendar_converter_unit.sv */
// Lunisolar calendar converter top level: six-stage Julian day <-> date pipeline.
//
// Converts a date (year, month, day) to a fixed-point Julian day number when
// op is 0, and a Julian day number back to year, month and day when op is 1.
// The block is a six-stage pipeline: a new request is taken every cycle while
// the response side keeps ready high. The stages hold the chain of constant
// multiplies (year estimate, then the new-year product beside the year mod
// 19), the one-year correction, the year kind and the final month scan.
// Backpressure stalls only the stages that are full, so bubbles close up
// while a result waits. A day number past the last month of a common year
// reports month 12, day 30 with clamped set.
module lunisolar_calendar_converter_unit
  import lcc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam logic signed [DIFF_W-1:0]  EPOCH_D  = DIFF_W'(EPOCH_FX);
  localparam logic signed [NY_W-1:0]    EPOCH_N  = NY_W'(EPOCH_FX);
  localparam logic signed [NY_W-1:0]    EPOCH_N1 = NY_W'(EPOCH_FX + SOLAR_FX);
  localparam logic signed [SOLAR_W-1:0] SOLAR_S  = SOLAR_W'(SOLAR_FX);
  localparam logic signed [RECIP_W-1:0] RECIP_S  = RECIP_W'(RECIP);
  localparam logic [MOD_W-1:0]          MOD_M    = MOD_W'(MOD_MUL);
  localparam logic [UW-1:0]             MOD_O    = UW'(MOD_OFF);
  localparam logic [UW-1:0]             MOD_C    = UW'(MOD_CYCLE);

  logic [6:1] v;
  logic [7:1] adv;

  always_comb begin
    adv[7] = rsp_ready;
    for (int k = 6; k >= 1; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign req_ready = adv[1];
  assign rsp_valid = v[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) v[1] <= req_valid;
      for (int k = 2; k <= 6; k++) begin
        if (adv[k]) v[k] <= v[k-1];
      end
    end
  end

  // Stage 1: day offset from epoch, whole days.
  logic                      s1_op;
  logic [DN_W-1:0]           s1_jd;
  logic [YEAR_W-1:0]         s1_year;
  logic [MONTH_W-1:0]        s1_month;
  logic [DAY_W-1:0]          s1_day;
  logic signed [DAYS_W-1:0]  s1_days;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [DIFF_W-1:0]  diff_sh;

  assign diff    = $signed({{(DIFF_W-DN_W){1'b0}}, req.day_number_in}) - EPOCH_D;
  assign diff_sh = diff >>> FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_op    <= req.op;
      s1_jd    <= req.day_number_in;
      s1_year  <= req.year_in;
      s1_month <= req.month_in;
      s1_day   <= req.day_in;
      s1_days  <= diff_sh[DAYS_W-1:0];
    end
  end

  // Stage 2: year estimate, or the given year.
  logic                    s2_op;
  logic [DN_W-1:0]         s2_jd;
  logic [MONTH_W-1:0]      s2_month;
  logic [DAY_W-1:0]        s2_day;
  logic signed [YW-1:0]    s2_y;
  logic signed [DAYS_W+RECIP_W-1:0] est_prod;
  logic signed [DAYS_W+RECIP_W-1:0] est_sh;

  assign est_prod = s1_days * RECIP_S;
  assign est_sh   = est_prod >>> RECIP_SHIFT;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_op    <= s1_op;
      s2_jd    <= s1_jd;
      s2_month <= s1_month;
      s2_day   <= s1_day;
      s2_y     <= (s1_op == OP_TO_DAY) ? {{(YW-YEAR_W){s1_year[YEAR_W-1]}}, s1_year}
                                       : est_sh[YW-1:0];
    end
  end

  // Stage 3: new-year product and mod-19 quotient.
  logic                     s3_op;
  logic [DN_W-1:0]          s3_jd;
  logic [MONTH_W-1:0]       s3_month;
  logic [DAY_W-1:0]         s3_day;
  logic signed [YW-1:0]     s3_y;
  logic [UW-1:0]            s3_q;
  logic signed [PROD_W-1:0] s3_prod;
  logic [UW-1:0]            u2;
  logic [UW+MOD_W-1:0]      q_prod;
  logic [UW+MOD_W-1:0]      q_sh;
  logic signed [PROD_W-1:0] ny_prod;

  assign u2      = {s2_y[YW-1], s2_y} + MOD_O;
  assign q_prod  = u2 * MOD_M;
  assign q_sh    = q_prod >> MOD_SHIFT;
  assign ny_prod = s2_y * SOLAR_S;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_op    <= s2_op;
      s3_jd    <= s2_jd;
      s3_month <= s2_month;
      s3_day   <= s2_day;
      s3_y     <= s2_y;
      s3_q     <= q_sh[UW-1:0];
      s3_prod  <= ny_prod;
    end
  end

  // Stage 4: new year, one-year correction, position in the 19-year cycle.
  logic                   s4_op;
  logic [DN_W-1:0]        s4_jd;
  logic [MONTH_W-1:0]     s4_month;
  logic [DAY_W-1:0]       s4_day;
  logic signed [YW-1:0]   s4_y;
  logic signed [NY_W-1:0] s4_ny;
  logic [POS_W-1:0]       s4_pos;
  logic signed [NY_W-1:0] j3;
  logic signed [NY_W-1:0] ny_lo;
  logic signed [NY_W-1:0] ny_hi;
  logic [UW-1:0]          u3;
  logic [UW-1:0]          pos_full;
  logic [POS_W-1:0]       pos;
  logic [POS_W-1:0]       pos_dn;
  logic [POS_W-1:0]       pos_up;
  logic                   below;
  logic                   above;

  assign j3       = $signed({{(NY_W-DN_W){1'b0}}, s3_jd});
  assign ny_lo    = $signed({{(NY_W-PROD_W){s3_prod[PROD_W-1]}}, s3_prod}) + EPOCH_N;
  assign ny_hi    = $signed({{(NY_W-PROD_W){s3_prod[PROD_W-1]}}, s3_prod}) + EPOCH_N1;
  assign u3       = {s3_y[YW-1], s3_y} + MOD_O;
  assign pos_full = u3 - s3_q * MOD_C;
  assign pos      = pos_full[POS_W-1:0];
  assign pos_dn   = (pos == '0) ? LAST_POS : pos - POS_W'(1);
  assign pos_up   = (pos == LAST_POS) ? '0 : pos + POS_W'(1);
  assign below    = (s3_op == OP_TO_DATE) && (j3 < ny_lo);
  assign above    = (s3_op == OP_TO_DATE) && (j3 >= ny_hi);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_op    <= s3_op;
      s4_jd    <= s3_jd;
      s4_month <= s3_month;
      s4_day   <= s3_day;
      if (below) begin
        s4_y   <= s3_y - YW'(1);
        s4_ny  <= ny_lo - $signed({{(NY_W-SOLAR_W){1'b0}}, SOLAR_S});
        s4_pos <= pos_dn;
      end else if (above) begin
        s4_y   <= s3_y + YW'(1);
        s4_ny  <= ny_hi;
        s4_pos <= pos_up;
      end else begin
        s4_y   <= s3_y;
        s4_ny  <= ny_lo;
        s4_pos <= pos;
      end
    end
  end

  // Stage 5: year kind and day of year.
  logic                   s5_op;
  logic [DN_W-1:0]        s5_jd;
  logic [MONTH_W-1:0]     s5_month;
  logic [DAY_W-1:0]       s5_day;
  logic signed [YW-1:0]   s5_y;
  logic signed [NY_W-1:0] s5_ny;
  logic [REM_W-1:0]       s5_rem;
  logic [KIND_W-1:0]      s5_kind;
  logic signed [NY_W-1:0] off4;
  logic signed [NY_W-1:0] off4_sh;

  assign off4    = $signed({{(NY_W-DN_W){1'b0}}, s4_jd}) - s4_ny;
  assign off4_sh = off4 >>> FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_op    <= s4_op;
      s5_jd    <= s4_jd;
      s5_month <= s4_month;
      s5_day   <= s4_day;
      s5_y     <= s4_y;
      s5_ny    <= s4_ny;
      s5_rem   <= off4_sh[REM_W-1:0];
      s5_kind  <= kind_of(s4_pos);
    end
  end

  // Stage 6: month scan, or new year plus days before the date.
  logic [MONTH_W-1:0]      fm;
  logic [DAY_W-1:0]        fd;
  logic                    cl;
  logic [REM_W-1:0]        fd_full;
  logic [DOY_W-1:0]        doy1;
  logic [DN_W-1:0]         dn;

  always_comb begin
    fm      = LAST_MONTH;
    fd      = LAST_DAY;
    cl      = 1'b1;
    fd_full = '0;
    for (int m = MONTHS - 1; m >= 0; m--) begin
      if (s5_rem < month_start(s5_kind, MONTH_W'(m + 1))) begin
        fm      = MONTH_W'(m);
        fd_full = s5_rem - month_start(s5_kind, MONTH_W'(m)) + REM_W'(1);
        fd      = fd_full[DAY_W-1:0];
        cl      = 1'b0;
      end
    end
  end

  assign doy1 = DOY_W'(month_start(s5_kind, s5_month)) + DOY_W'(s5_day) - DOY_W'(1);
  assign dn   = s5_ny[DN_W-1:0] +
                ({{(DN_W-DOY_W){doy1[DOY_W-1]}}, doy1} << FRACTION_BITS);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      rsp.year_out  <= s5_y[YEAR_W-1:0];
      rsp.year_kind <= s5_kind;
      if (s5_op == OP_TO_DATE) begin
        rsp.day_number_out <= s5_jd;
        rsp.month_out      <= fm;
        rsp.day_out        <= fd;
        rsp.clamped        <= cl;
      end else begin
        rsp.day_number_out <= dn;
        rsp.month_out      <= s5_month;
        rsp.day_out        <= s5_day;
        rsp.clamped        <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/lcc_checker.sv */
// Port-level assertions for the lunisolar calendar converter, bound to the top level.
module lcc_checker
  import lcc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // A waiting result holds until its transfer.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // With the response side kept ready, an accepted request comes out as a valid result.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
      ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
    else $error("result missing after pipeline latency");

  // Clamping only happens past the end of a common year.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.clamped |->
      rsp.month_out == LAST_MONTH && rsp.day_out == LAST_DAY &&
      rsp.year_kind == KIND_COMMON)
    else $error("clamped result with wrong date or year kind");

endmodule

bind lunisolar_calendar_converter_unit lcc_checker u_lcc_checker (.*);
